>>> sv/tscw_pkg.sv
// Package for the text screen character writer: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.
package tscw_pkg;

    localparam int MaxCols  = 128;
    localparam int MaxRows  = 64;
    localparam int TabWidth = 8;
    localparam int ColW     = 8;
    localparam int RowW     = 6;
    localparam int AddrW    = 13;
    localparam int CellW    = 58;

    // Control bytes and printable threshold.
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_FIRST_PRINT = 8'd32;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_COLS   = 3'd0;
    localparam logic [2:0] REG_ROWS   = 3'd1;
    localparam logic [2:0] REG_TOP    = 3'd2;
    localparam logic [2:0] REG_BOTTOM = 3'd3;
    localparam logic [2:0] REG_FORE   = 3'd4;
    localparam logic [2:0] REG_BACK   = 3'd5;
    localparam logic [2:0] REG_BOLD   = 3'd6;
    localparam logic [2:0] REG_INV    = 3'd7;

    localparam logic [23:0] FORE_RESET = 24'hE0E0E0;
    localparam logic [23:0] BACK_RESET = 24'h1A1B26;

    // Item class decided by the front part.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_CR    = 3'd1;
    localparam logic [2:0] OP_LF    = 3'd2;
    localparam logic [2:0] OP_TAB   = 3'd3;
    localparam logic [2:0] OP_BS    = 3'd4;
    localparam logic [2:0] OP_PRINT = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  cursor_col;
        logic [5:0]  cursor_row;
        logic        cell_written;
        logic [6:0]  cell_col;
        logic [5:0]  cell_row;
        logic [7:0]  cell_char;
        logic [23:0] cell_fore;
        logic [23:0] cell_back;
        logic        cell_bold;
        logic        cell_inverse;
        logic        region_scrolled;
        logic        burst_done;
    } result_t;

endpackage

>>> sv/tscw_in_if.sv
// Input channel of the character writer: one stream byte per item.
// Depends on nothing but the handshake signals it carries.
interface tscw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       burst_last;

    modport source (output valid, output char_byte, output burst_last, input ready);
    modport sink (input valid, input char_byte, input burst_last, output ready);
endinterface

>>> sv/tscw_out_if.sv
// Output channel of the character writer: one result item per byte.
// Depends on nothing but the handshake signals it carries.
interface tscw_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic        cell_written;
    logic [6:0]  cell_col;
    logic [5:0]  cell_row;
    logic [7:0]  cell_char;
    logic [23:0] cell_fore;
    logic [23:0] cell_back;
    logic        cell_bold;
    logic        cell_inverse;
    logic        region_scrolled;
    logic        burst_done;

    modport source (output valid, output cursor_col, output cursor_row, output cell_written,
                    output cell_col, output cell_row, output cell_char, output cell_fore,
                    output cell_back, output cell_bold, output cell_inverse,
                    output region_scrolled, output burst_done, input ready);
    modport sink (input valid, input cursor_col, input cursor_row, input cell_written,
                  input cell_col, input cell_row, input cell_char, input cell_fore,
                  input cell_back, input cell_bold, input cell_inverse,
                  input region_scrolled, input burst_done, output ready);
endinterface

>>> sv/tscw_front.sv
// Front part: accepts stream bytes, classifies them and queues commands.
// Depends on tscw_pkg and tscw_in_if.
module tscw_front (
    input  logic              clk,
    input  logic              rst_n,
    tscw_in_if.sink           in_ch,
    output tscw_pkg::cmd_t    cmd,
    output logic              cmd_valid,
    input  logic              cmd_pop
);

    tscw_pkg::cmd_t fifo_reg [2];
    logic [0:0]     wptr_reg;
    logic [0:0]     rptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    tscw_pkg::cmd_t classified;

    // Decode the byte into an operation class.
    always_comb
    begin
        classified.ch   = in_ch.char_byte;
        classified.last = in_ch.burst_last;
        case (in_ch.char_byte)
            tscw_pkg::CH_CR:  classified.op = tscw_pkg::OP_CR;
            tscw_pkg::CH_LF:  classified.op = tscw_pkg::OP_LF;
            tscw_pkg::CH_TAB: classified.op = tscw_pkg::OP_TAB;
            tscw_pkg::CH_BS:  classified.op = tscw_pkg::OP_BS;
            default:
            begin
                if (in_ch.char_byte >= tscw_pkg::CH_FIRST_PRINT)
                    classified.op = tscw_pkg::OP_PRINT;
                else
                    classified.op = tscw_pkg::OP_NONE;
            end
        endcase
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (count_reg != 2'd0);
    assign cmd         = fifo_reg[rptr_reg];

    // Two-entry command queue.
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wptr_reg] <= classified;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (cmd_pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

endmodule

>>> sv/tscw_back.sv
// Back part: moves the cursor, writes cells and scrolls the region of the store.
// Depends on tscw_pkg; holds the cell store as a local memory.
module tscw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tscw_pkg::cmd_t       cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  logic [7:0]           cols,
    input  logic [6:0]           rows,
    input  logic [5:0]           top,
    input  logic [5:0]           bot,
    input  logic [23:0]          fore_color,
    input  logic [23:0]          back_color,
    input  logic                 bold_on,
    input  logic                 inverse_on,
    output tscw_pkg::result_t    res,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_COPYR = 3'd2;
    localparam logic [2:0] S_COPYW = 3'd3;
    localparam logic [2:0] S_BLANK = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [tscw_pkg::CellW-1:0] mem [1 << tscw_pkg::AddrW];
    logic [tscw_pkg::CellW-1:0] rdata_reg;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  col_reg, col_next;
    logic [5:0]  row_reg, row_next;
    logic [13:0] clr_reg, clr_next;
    logic [5:0]  crow_reg, crow_next;
    logic [6:0]  ccol_reg, ccol_next;
    tscw_pkg::cmd_t    cur_reg, cur_next;
    logic              scr_reg, scr_next;
    tscw_pkg::result_t res_reg, res_next;
    logic              rv_reg, rv_next;

    logic        we;
    logic [12:0] waddr;
    logic [57:0] wdata;
    logic [12:0] raddr;
    logic [7:0]  ccol;
    logic [5:0]  crow;
    logic [7:0]  tabn;
    logic [23:0] sf, sb;

    assign res       = res_reg;
    assign res_valid = rv_reg;
    assign busy      = (state_reg != S_IDLE) || rv_reg;

    // Cursor after the stale-cursor clamp.
    assign ccol = (col_reg > cols) ? cols : col_reg;
    assign crow = ({1'b0, row_reg} > rows - 7'd1) ? 6'(rows - 7'd1) : row_reg;
    assign tabn = {ccol[7:3], 3'b000} + 8'(tscw_pkg::TabWidth);
    assign sf   = inverse_on ? back_color : fore_color;
    assign sb   = inverse_on ? fore_color : back_color;
    assign raddr = {6'(crow_reg + 6'd1), ccol_reg};

    // Cell store with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        clr_next   = clr_reg;
        crow_next  = crow_reg;
        ccol_next  = ccol_reg;
        cur_next   = cur_reg;
        scr_next   = scr_reg;
        res_next   = res_reg;
        rv_next    = rv_reg;
        cmd_pop    = 1'b0;
        we         = 1'b0;
        waddr      = clr_reg[12:0];
        wdata      = '0;
        if (rv_reg && res_ready)
            rv_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + 14'd1;
                if (clr_reg == 14'((1 << tscw_pkg::AddrW) - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid && !(rv_reg && !res_ready))
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    scr_next = 1'b0;
                    col_next = ccol;
                    row_next = crow;
                    case (cmd.op)
                        tscw_pkg::OP_CR: col_next = 8'd0;
                        tscw_pkg::OP_TAB:
                            col_next = (tabn < cols - 8'd1) ? tabn : cols - 8'd1;
                        tscw_pkg::OP_BS:
                            if (ccol > cols - 8'd1)
                                col_next = cols - 8'd1;
                            else if (ccol != 8'd0)
                                col_next = ccol - 8'd1;
                        tscw_pkg::OP_LF, tscw_pkg::OP_PRINT:
                        begin
                            if (cmd.op == tscw_pkg::OP_PRINT && ccol >= cols)
                                col_next = 8'd0;
                            if (cmd.op == tscw_pkg::OP_LF || ccol >= cols)
                            begin
                                if (crow == bot)
                                begin
                                    scr_next  = 1'b1;
                                    crow_next = top;
                                    ccol_next = 7'd0;
                                end
                                else if ({1'b0, crow} + 7'd1 < rows)
                                    row_next = crow + 6'd1;
                            end
                        end
                        default: ;
                    endcase
                    if (scr_next)
                        state_next = (top == bot) ? S_BLANK : S_COPYR;
                    else
                        state_next = S_WRITE;
                end
            end
            S_COPYR:
                state_next = S_COPYW;
            S_COPYW:
            begin
                we    = 1'b1;
                waddr = {crow_reg, ccol_reg};
                wdata = rdata_reg;
                ccol_next = ccol_reg + 7'd1;
                state_next = S_COPYR;
                if (ccol_reg == 7'(tscw_pkg::MaxCols - 1))
                begin
                    crow_next = crow_reg + 6'd1;
                    if (crow_reg + 6'd1 == bot)
                        state_next = S_BLANK;
                end
            end
            S_BLANK:
            begin
                we    = 1'b1;
                waddr = {bot, ccol_reg};
                ccol_next = ccol_reg + 7'd1;
                if (ccol_reg == 7'(tscw_pkg::MaxCols - 1))
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                res_next = '0;
                res_next.burst_done      = cur_reg.last;
                res_next.region_scrolled = scr_reg;
                res_next.cursor_col      = col_reg;
                res_next.cursor_row      = row_reg;
                if (cur_reg.op == tscw_pkg::OP_PRINT)
                begin
                    we    = 1'b1;
                    waddr = {row_reg, col_reg[6:0]};
                    wdata = {inverse_on, bold_on, sb, sf, cur_reg.ch};
                    res_next.cell_written = 1'b1;
                    res_next.cell_col     = col_reg[6:0];
                    res_next.cell_row     = row_reg;
                    res_next.cell_char    = cur_reg.ch;
                    res_next.cell_fore    = sf;
                    res_next.cell_back    = sb;
                    res_next.cell_bold    = bold_on;
                    res_next.cell_inverse = inverse_on;
                    res_next.cursor_col   = col_reg + 8'd1;
                    col_next              = col_reg + 8'd1;
                end
                rv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            col_reg   <= 8'd0;
            row_reg   <= 6'd0;
            clr_reg   <= 14'd0;
            crow_reg  <= 6'd0;
            ccol_reg  <= 7'd0;
            scr_reg   <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            clr_reg   <= clr_next;
            crow_reg  <= crow_next;
            ccol_reg  <= ccol_next;
            scr_reg   <= scr_next;
            rv_reg    <= rv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

endmodule

>>> sv/text_screen_char_writer.sv
// Top level: a non-scrolling byte goes from the queue through the idle and write states
// to a registered result; a new byte is taken once the last result is accepted.
// A scroll copies each row moved over all 128 columns, a read and a write state per
// cell, then blanks the bottom row. Registers reset to defaults; a pass after reset
// blanks all 8192 cells while at most two items queue and register writes are taken.
module text_screen_char_writer (
    input  logic        clk,
    input  logic        rst_n,
    tscw_in_if.sink     in_ch,
    tscw_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  cols_reg;
    logic [6:0]  rows_reg;
    logic [5:0]  top_reg, bot_reg;
    logic [23:0] fore_reg, back_reg;
    logic        bold_reg, inv_reg;
    logic [7:0]  cols;
    logic [6:0]  rows;
    logic [5:0]  top, bot, botc;
    logic [2:0]  idx;
    tscw_pkg::cmd_t    cmd;
    logic              cmd_valid, cmd_pop, busy;
    tscw_pkg::result_t res;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 8'd80;
            rows_reg <= 7'd25;
            top_reg  <= 6'd0;
            bot_reg  <= 6'd24;
            fore_reg <= tscw_pkg::FORE_RESET;
            back_reg <= tscw_pkg::BACK_RESET;
            bold_reg <= 1'b0;
            inv_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                tscw_pkg::REG_COLS:   cols_reg <= pwdata[7:0];
                tscw_pkg::REG_ROWS:   rows_reg <= pwdata[6:0];
                tscw_pkg::REG_TOP:    top_reg  <= pwdata[5:0];
                tscw_pkg::REG_BOTTOM: bot_reg  <= pwdata[5:0];
                tscw_pkg::REG_FORE:   fore_reg <= pwdata[23:0];
                tscw_pkg::REG_BACK:   back_reg <= pwdata[23:0];
                tscw_pkg::REG_BOLD:   bold_reg <= pwdata[0];
                tscw_pkg::REG_INV:    inv_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (idx)
            tscw_pkg::REG_COLS:   prdata = {24'd0, cols_reg};
            tscw_pkg::REG_ROWS:   prdata = {25'd0, rows_reg};
            tscw_pkg::REG_TOP:    prdata = {26'd0, top_reg};
            tscw_pkg::REG_BOTTOM: prdata = {26'd0, bot_reg};
            tscw_pkg::REG_FORE:   prdata = {8'd0, fore_reg};
            tscw_pkg::REG_BACK:   prdata = {8'd0, back_reg};
            tscw_pkg::REG_BOLD:   prdata = {31'd0, bold_reg};
            default:              prdata = {31'd0, inv_reg};
        endcase
    end

    // Clamped geometry.
    assign cols = (cols_reg == 8'd0) ? 8'd1 : (cols_reg > 8'd128 ? 8'd128 : cols_reg);
    assign rows = (rows_reg == 7'd0) ? 7'd1 : (rows_reg > 7'd64 ? 7'd64 : rows_reg);
    assign top  = ({1'b0, top_reg} > rows - 7'd1) ? 6'(rows - 7'd1) : top_reg;
    assign botc = ({1'b0, bot_reg} > rows - 7'd1) ? 6'(rows - 7'd1) : bot_reg;
    assign bot  = (botc < top) ? top : botc;

    tscw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    tscw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cols       (cols),
        .rows       (rows),
        .top        (top),
        .bot        (bot),
        .fore_color (fore_reg),
        .back_color (back_reg),
        .bold_on    (bold_reg),
        .inverse_on (inv_reg),
        .res        (res),
        .res_valid  (out_ch.valid),
        .res_ready  (out_ch.ready),
        .busy       (busy)
    );

    assign out_ch.cursor_col      = res.cursor_col;
    assign out_ch.cursor_row      = res.cursor_row;
    assign out_ch.cell_written    = res.cell_written;
    assign out_ch.cell_col        = res.cell_col;
    assign out_ch.cell_row        = res.cell_row;
    assign out_ch.cell_char       = res.cell_char;
    assign out_ch.cell_fore       = res.cell_fore;
    assign out_ch.cell_back       = res.cell_back;
    assign out_ch.cell_bold       = res.cell_bold;
    assign out_ch.cell_inverse    = res.cell_inverse;
    assign out_ch.region_scrolled = res.region_scrolled;
    assign out_ch.burst_done      = res.burst_done;

`ifndef SYNTHESIS
    // A cell is never reported written without the cursor having moved past it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.cell_written |-> out_ch.cursor_col != 8'd0)
        else $error("written cell with cursor at column zero");
    // The back part is busy whenever a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> busy)
        else $error("result pending while back part idle");
    // A command is only taken when one is queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from empty queue");
`endif

endmodule

>>> sim/tb_text_screen_char_writer.sv
`timescale 1ns / 100ps
// Testbench for text_screen_char_writer: directed and random byte streams over
// several screen settings, checked against a cursor predictor.
// Needs tscw_pkg and the interfaces.
module tb_text_screen_char_writer;

    // Predicts the cursor and cell write of each byte and holds the results still due.
    class screen_scoreboard;
        logic [7:0]  cols_reg = 8'd80;
        logic [6:0]  rows_reg = 7'd25;
        logic [5:0]  top_reg = 6'd0;
        logic [5:0]  bottom_reg = 6'd24;
        logic [23:0] fore_reg = tscw_pkg::FORE_RESET;
        logic [23:0] back_reg = tscw_pkg::BACK_RESET;
        logic        bold_reg = 1'b0;
        logic        inv_reg = 1'b0;
        int          cur_col = 0;
        int          cur_row = 0;
        tscw_pkg::result_t due_results[$];
        int          errors = 0;
        int          checked = 0;
        int          scrolls = 0;
        int          wraps = 0;

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                tscw_pkg::REG_COLS:   cols_reg = v[7:0];
                tscw_pkg::REG_ROWS:   rows_reg = v[6:0];
                tscw_pkg::REG_TOP:    top_reg = v[5:0];
                tscw_pkg::REG_BOTTOM: bottom_reg = v[5:0];
                tscw_pkg::REG_FORE:   fore_reg = v[23:0];
                tscw_pkg::REG_BACK:   back_reg = v[23:0];
                tscw_pkg::REG_BOLD:   bold_reg = v[0];
                default:              inv_reg = v[0];
            endcase
        endfunction

        // Value a register read should return.
        function logic [31:0] get_reg(logic [2:0] idx);
            case (idx)
                tscw_pkg::REG_COLS:   return {24'd0, cols_reg};
                tscw_pkg::REG_ROWS:   return {25'd0, rows_reg};
                tscw_pkg::REG_TOP:    return {26'd0, top_reg};
                tscw_pkg::REG_BOTTOM: return {26'd0, bottom_reg};
                tscw_pkg::REG_FORE:   return {8'd0, fore_reg};
                tscw_pkg::REG_BACK:   return {8'd0, back_reg};
                tscw_pkg::REG_BOLD:   return {31'd0, bold_reg};
                default:              return {31'd0, inv_reg};
            endcase
        endfunction

        // Line feed: scrolls on the bottom row of the region, else moves down unless on the last row.
        function bit feed_line(int rows, int bot);
            if (cur_row == bot)
                return 1'b1;
            if (cur_row + 1 < rows)
                cur_row++;
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] ch, logic last);
            tscw_pkg::result_t r;
            int cols, rows, top, bot, nxt;
            r = '0;
            cols = (cols_reg < 1) ? 1 :
                   (cols_reg > tscw_pkg::MaxCols) ? tscw_pkg::MaxCols : cols_reg;
            rows = (rows_reg < 1) ? 1 :
                   (rows_reg > tscw_pkg::MaxRows) ? tscw_pkg::MaxRows : rows_reg;
            top = (top_reg > rows - 1) ? rows - 1 : top_reg;
            bot = (bottom_reg > rows - 1) ? rows - 1 : bottom_reg;
            if (bot < top)
                bot = top;
            if (cur_col > cols)
                cur_col = cols;
            if (cur_row > rows - 1)
                cur_row = rows - 1;
            if (ch == tscw_pkg::CH_CR)
                cur_col = 0;
            else if (ch == tscw_pkg::CH_LF)
                r.region_scrolled = feed_line(rows, bot);
            else if (ch == tscw_pkg::CH_TAB)
            begin
                nxt = (cur_col / tscw_pkg::TabWidth + 1) * tscw_pkg::TabWidth;
                cur_col = (nxt < cols - 1) ? nxt : cols - 1;
            end
            else if (ch == tscw_pkg::CH_BS)
            begin
                if (cur_col > 0)
                    cur_col--;
            end
            else if (ch >= tscw_pkg::CH_FIRST_PRINT)
            begin
                // A pending wrap is resolved before the character is stored.
                if (cur_col >= cols)
                begin
                    cur_col = 0;
                    wraps++;
                    r.region_scrolled = feed_line(rows, bot);
                end
                r.cell_written = 1'b1;
                r.cell_col = cur_col[6:0];
                r.cell_row = cur_row[5:0];
                r.cell_char = ch;
                r.cell_inverse = inv_reg;
                r.cell_bold = bold_reg;
                r.cell_fore = inv_reg ? back_reg : fore_reg;
                r.cell_back = inv_reg ? fore_reg : back_reg;
                cur_col++;
            end
            if (r.region_scrolled)
                scrolls++;
            r.cursor_col = cur_col[7:0];
            r.cursor_row = cur_row[5:0];
            r.burst_done = last;
            due_results.insert(due_results.size(), r);
        endfunction

        function void field(string name, logic [23:0] exp_v, logic [23:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(tscw_pkg::result_t a);
            tscw_pkg::result_t e;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %p", $time, a);
                return;
            end
            e = due_results.pop_front();
            checked++;
            field("cursor_col", e.cursor_col, a.cursor_col);
            field("cursor_row", e.cursor_row, a.cursor_row);
            field("cell_written", e.cell_written, a.cell_written);
            field("cell_col", e.cell_col, a.cell_col);
            field("cell_row", e.cell_row, a.cell_row);
            field("cell_char", e.cell_char, a.cell_char);
            field("cell_fore", e.cell_fore, a.cell_fore);
            field("cell_back", e.cell_back, a.cell_back);
            field("cell_bold", e.cell_bold, a.cell_bold);
            field("cell_inverse", e.cell_inverse, a.cell_inverse);
            field("region_scrolled", e.region_scrolled, a.region_scrolled);
            field("burst_done", e.burst_done, a.burst_done);
        endfunction
    endclass

    localparam int CycleLimit = 6000000;
    localparam int HoldCycles = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          cycles = 0;
    int          sent = 0;

    tscw_in_if  in_ch ();
    tscw_out_if out_ch ();
    screen_scoreboard board = new();

    text_screen_char_writer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.char_byte = '0;
        in_ch.burst_last = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Accepted bytes and results are both taken at the rising edge.
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            board.note_byte(in_ch.char_byte, in_ch.burst_last);
        if (out_ch.valid && out_ch.ready)
            board.check_result('{out_ch.cursor_col, out_ch.cursor_row, out_ch.cell_written,
                                 out_ch.cell_col, out_ch.cell_row, out_ch.cell_char,
                                 out_ch.cell_fore, out_ch.cell_back, out_ch.cell_bold,
                                 out_ch.cell_inverse, out_ch.region_scrolled,
                                 out_ch.burst_done});
    end

    // Result side: random stalls, plus one long hold-off on request.
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            out_ch.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clk);
            hold_req = 1'b0;
        end
        else
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 21);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_reg(idx, v);
        // The address is still presented, so the read port shows the new value.
        if (!pready || prdata !== board.get_reg(idx))
        begin
            board.errors++;
            $display("%0t: register %0d read back, expected %0h, actual %0h",
                     $time, idx, board.get_reg(idx), prdata);
        end
    endtask

    task automatic set_screen(int cols, int rows, int top, int bottom);
        write_reg(tscw_pkg::REG_COLS, cols);
        write_reg(tscw_pkg::REG_ROWS, rows);
        write_reg(tscw_pkg::REG_TOP, top);
        write_reg(tscw_pkg::REG_BOTTOM, bottom);
    endtask

    task automatic set_attrs(logic [23:0] fore, logic [23:0] back, bit bold, bit inv);
        write_reg(tscw_pkg::REG_FORE, {8'd0, fore});
        write_reg(tscw_pkg::REG_BACK, {8'd0, back});
        write_reg(tscw_pkg::REG_BOLD, {31'd0, bold});
        write_reg(tscw_pkg::REG_INV, {31'd0, inv});
    endtask

    // Offers one byte, idling at random first, and returns once it is taken.
    task automatic send_byte(logic [7:0] ch, logic last);
        while (!no_idle && $urandom_range(0, 99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.char_byte <= ch;
        in_ch.burst_last <= last;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready))
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Waits until every result is in, with the byte channel quiet.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly printable text with line feeds, a few other controls and noise.
    task automatic random_bytes(int n);
        int k;
        logic [7:0] ch;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 8)
                ch = tscw_pkg::CH_LF;
            else if (k < 13)
                ch = tscw_pkg::CH_CR;
            else if (k < 18)
                ch = tscw_pkg::CH_TAB;
            else if (k < 23)
                ch = tscw_pkg::CH_BS;
            else if (k < 28)
                ch = 8'($urandom_range(0, 31));
            else
                ch = 8'($urandom_range(32, 255));
            send_byte(ch, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [7:0] directed_bytes[$];
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: extremes of the byte range and each control byte.
        directed_bytes = '{8'h00, 8'h1F, 8'h20, 8'hFF, tscw_pkg::CH_TAB, tscw_pkg::CH_BS,
                           tscw_pkg::CH_CR, tscw_pkg::CH_LF, 8'h1B};
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i], i[0]);
        drain();

        // Eight columns, two rows: pending wrap, scroll, tab and backspace after a wrap.
        set_screen(8, 2, 0, 1);
        set_attrs(24'hFFFFFF, 24'h000000, 1'b1, 1'b1);
        directed_bytes = '{tscw_pkg::CH_LF, tscw_pkg::CH_LF, 8'h41, 8'h42, 8'h43, 8'h44,
                           8'h45, 8'h46, 8'h47, 8'h48, tscw_pkg::CH_TAB, 8'h49, 8'h4A,
                           tscw_pkg::CH_BS, 8'h7F, 8'h80};
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i], 1'b1);
        drain();

        // Random phases over clamped and ordinary sizes and regions.
        for (int ph = 0; ph < 9; ph++)
        begin
            int cols, rows, top;
            case (ph)
                0: set_screen(0, 0, 63, 0);
                1: set_screen(255, 127, 10, 5);
                2: set_screen(1, 64, 62, 63);
                3: set_screen(128, 64, 0, 63);
                default:
                begin
                    cols = $urandom_range(0, 255);
                    rows = $urandom_range(0, 127);
                    top = $urandom_range(0, 63);
                    set_screen(cols, rows, top, top + $urandom_range(0, 3));
                end
            endcase
            set_attrs(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            no_idle = (ph == 4);
            if (ph == 3)
                random_bytes(60);
            else if (ph == 5)
            begin
                random_bytes(40);
                hold_req = 1'b1;
                random_bytes(160);
            end
            else
                random_bytes(200);
            drain();
        end
        no_idle = 1'b0;
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes, checked %0d results, %0d scrolls, %0d wraps.",
                 sent, board.checked, board.scrolls, board.wraps);
        if (board.errors == 0 && board.due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> sim.f
sv/tscw_pkg.sv
sv/tscw_in_if.sv
sv/tscw_out_if.sv
sv/tscw_front.sv
sv/tscw_back.sv
sv/text_screen_char_writer.sv
sim/tb_text_screen_char_writer.sv
